>>> rtl/json_string_escaper_assert.svh
// Assertion macros for the JSON string escaper.
// Each macro checks an implication on the rising clock edge, outside of reset.
`ifndef JSON_STRING_ESCAPER_ASSERT_SVH
`define JSON_STRING_ESCAPER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define JSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define JSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define JSE_ASSERT_IMPL(lbl, ante, cons, msg)
`define JSE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/jse_pkg.sv
package jse_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PendDepth = 3;
  localparam int unsigned MaxEnt    = 4;

  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharU      = 8'h75;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CtrlLimit  = 8'h20;

  // How one entry turns into output text
  typedef enum logic [1:0] {
    KIND_RAW = 2'd0,  // byte as is
    KIND_ESC = 2'd1,  // backslash, then the stored letter
    KIND_HEX = 2'd2   // \u00xx of the stored byte
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    kind_e            kind;
  } entry_t;

  // Map a code point below 0x80 to its escape form
  function automatic entry_t ascii_entry(logic [ByteW-1:0] c);
    entry_t e;
    e.data = c;
    e.kind = KIND_RAW;
    unique case (c)
      8'h08: begin e.data = 8'h62; e.kind = KIND_ESC; end  // b
      8'h0C: begin e.data = 8'h66; e.kind = KIND_ESC; end  // f
      8'h0A: begin e.data = 8'h6E; e.kind = KIND_ESC; end  // n
      8'h0D: begin e.data = 8'h72; e.kind = KIND_ESC; end  // r
      8'h09: begin e.data = 8'h74; e.kind = KIND_ESC; end  // t
      8'h0B: begin e.data = 8'h76; e.kind = KIND_ESC; end  // v
      8'h22: begin e.data = 8'h22; e.kind = KIND_ESC; end  // quote
      8'h5C: begin e.data = 8'h5C; e.kind = KIND_ESC; end  // backslash
      default: begin
        if (c < CtrlLimit) begin
          e.kind = KIND_HEX;
        end
      end
    endcase
    return e;
  endfunction

  // Lowercase hex digit
  function automatic logic [ByteW-1:0] hex_digit(logic [3:0] v);
    logic [ByteW-1:0] d;
    if (v < 4'd10) begin
      d = CharZero + {4'd0, v};
    end else begin
      d = 8'h61 + {4'd0, v} - 8'd10;
    end
    return d;
  endfunction

  // Index of the last output character of an entry
  function automatic logic [2:0] entry_last_char(kind_e k);
    logic [2:0] n;
    unique case (k)
      KIND_RAW: n = 3'd0;
      KIND_ESC: n = 3'd1;
      KIND_HEX: n = 3'd5;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/json_string_escaper.sv
// JSON string escaper with strict UTF-8 checking.
//
// Input channel (in_valid_i / in_ready_o): one raw byte per transaction, with
// has_byte_i = 0 for a flush-only transaction and end_of_stream_i = 1 to flush
// an unfinished UTF-8 sequence as \u00xx escapes.
// Output channel (out_valid_o / out_ready_i): one escaped text byte per
// transaction; last_of_run_o marks the final byte caused by one input.
//
// An accepted input is decoded in its accept cycle into at most four entries
// (raw byte, two-byte escape or six-byte \u00xx escape). A small sequencer then
// drives one shared character generator, one output byte per cycle while the
// receiver is ready; the first byte is offered the cycle after acceptance.
// An input yielding nothing leaves the sequencer idle. At most 24 output bytes
// come from one input; a \u00xx escape is six bytes.
// in_ready_o is high only while no output is pending.
//
// Reset clears the pending sequence and returns the sequencer to idle.
// When the receiver stalls, the current byte is held and the sequencer waits.
`include "json_string_escaper_assert.svh"

module json_string_escaper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       has_byte_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);
  import jse_pkg::*;

  state_e           state_q, state_d;
  entry_t           ent_q [MaxEnt];
  entry_t           ent_d [MaxEnt];
  logic [2:0]       ent_cnt_q, ent_cnt_d;
  logic [1:0]       idx_q, idx_d;
  logic [2:0]       char_q, char_d;

  logic [ByteW-1:0] pend_q [PendDepth];
  logic [ByteW-1:0] pend_d [PendDepth];
  logic [1:0]       pcnt_q, pcnt_d;
  logic [2:0]       exp_q, exp_d;

  logic             in_fire, out_fire;
  logic [ByteW-1:0] b;
  logic [ByteW-1:0] lo, hi;
  logic             fits, complete, b_lead;
  logic [2:0]       b_len;
  logic             pk_emit, b_emit, b_store;
  kind_e            pk_kind;
  entry_t           b_ent;
  logic [2:0]       npe;
  logic [ByteW-1:0] src [MaxEnt];

  entry_t           cur;
  logic             char_last, ent_last;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;
  assign b           = in_byte_i;

  // Decode the incoming transaction against the pending sequence
  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    if (pcnt_q == 2'd1) begin
      unique case (pend_q[0])
        8'hE0:   lo = 8'hA0;
        8'hED:   hi = 8'h9F;
        8'hF0:   lo = 8'h90;
        8'hF4:   hi = 8'h8F;
        default: ;
      endcase
    end
    fits     = (b >= lo) && (b <= hi);
    complete = ((3'(pcnt_q) + 3'd1) >= exp_q);
    b_lead   = (b >= 8'hC2) && (b <= 8'hF4);
    b_len    = (b < 8'hE0) ? 3'd2 : ((b < 8'hF0) ? 3'd3 : 3'd4);

    pk_emit = 1'b0;
    pk_kind = KIND_HEX;
    b_emit  = 1'b0;
    b_store = 1'b0;
    b_ent   = '{data: b, kind: KIND_HEX};

    if (has_byte_i) begin
      if ((pcnt_q != 2'd0) && fits) begin
        pk_emit = complete || end_of_stream_i;
        b_emit  = complete || end_of_stream_i;
        b_store = !complete && !end_of_stream_i;
        if (complete) begin
          pk_kind = KIND_RAW;
          b_ent   = '{data: b, kind: KIND_RAW};
        end
      end else begin
        // fresh start, after escaping a broken sequence if there is one
        pk_emit = (pcnt_q != 2'd0);
        if (b < 8'h80) begin
          b_emit = 1'b1;
          b_ent  = ascii_entry(b);
        end else if (b_lead) begin
          b_emit = end_of_stream_i;
        end else begin
          b_emit = 1'b1;
        end
      end
    end else begin
      pk_emit = end_of_stream_i && (pcnt_q != 2'd0);
    end

    // Pending state update
    pend_d = pend_q;
    pcnt_d = pcnt_q;
    exp_d  = exp_q;
    if (has_byte_i || end_of_stream_i) begin
      if (b_store) begin
        pend_d[pcnt_q] = b;
        pcnt_d         = pcnt_q + 2'd1;
      end else if (has_byte_i && !((pcnt_q != 2'd0) && fits) && b_lead
                   && !end_of_stream_i) begin
        pend_d[0] = b;
        pcnt_d    = 2'd1;
        exp_d     = b_len;
      end else if (has_byte_i || pcnt_q != 2'd0) begin
        for (int j = 0; j < PendDepth; j++) begin
          pend_d[j] = '0;
        end
        pcnt_d = 2'd0;
        exp_d  = 3'd0;
      end
    end

    // Entry list: emitted pending bytes, then the new byte
    for (int j = 0; j < PendDepth; j++) begin
      src[j] = pend_q[j];
    end
    src[MaxEnt-1] = '0;
    npe = pk_emit ? 3'(pcnt_q) : 3'd0;
    for (int j = 0; j < MaxEnt; j++) begin
      if (3'(j) < npe) begin
        ent_d[j] = '{data: src[j], kind: pk_kind};
      end else begin
        ent_d[j] = b_ent;
      end
    end
    ent_cnt_d = npe + 3'(b_emit);
  end

  // Shared character generator
  always_comb begin
    cur = ent_q[idx_q];
    unique case (cur.kind)
      KIND_RAW: out_byte_o = cur.data;
      KIND_ESC: out_byte_o = (char_q == 3'd0) ? CharBslash : cur.data;
      KIND_HEX: begin
        unique case (char_q)
          3'd0:    out_byte_o = CharBslash;
          3'd1:    out_byte_o = CharU;
          3'd2:    out_byte_o = CharZero;
          3'd3:    out_byte_o = CharZero;
          3'd4:    out_byte_o = hex_digit(cur.data[7:4]);
          default: out_byte_o = hex_digit(cur.data[3:0]);
        endcase
      end
      default:  out_byte_o = cur.data;
    endcase
    char_last     = (char_q == entry_last_char(cur.kind));
    ent_last      = ((3'(idx_q) + 3'd1) == ent_cnt_q);
    last_of_run_o = char_last && ent_last;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    char_d  = char_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (ent_cnt_d != 3'd0)) begin
          state_d = ST_EMIT;
          idx_d   = 2'd0;
          char_d  = 3'd0;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (char_last) begin
            char_d = 3'd0;
            if (ent_last) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end else begin
            char_d = char_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= 2'd0;
      char_q    <= 3'd0;
      ent_cnt_q <= 3'd0;
      pcnt_q    <= 2'd0;
      exp_q     <= 3'd0;
      for (int j = 0; j < PendDepth; j++) begin
        pend_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      char_q  <= char_d;
      if (in_fire) begin
        ent_cnt_q <= ent_cnt_d;
        pcnt_q    <= pcnt_d;
        exp_q     <= exp_d;
        pend_q    <= pend_d;
      end
    end
  end

  // Entry payload, loaded per input transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ent_q <= ent_d;
    end
  end

  // Checks
  `JSE_ASSERT_IMPL(a_no_overlap, out_valid_o, !in_ready_o, "input taken while output pending")
  `JSE_ASSERT_IMPL(a_idx_range, out_valid_o, ent_cnt_q > 3'(idx_q), "entry index out of range")
  `JSE_ASSERT_IMPL(a_pend_short, pcnt_q != 2'd0, 3'(pcnt_q) < exp_q, "pending sequence overfull")
  `JSE_ASSERT_NEXT(a_run_done, out_valid_o && out_ready_i && last_of_run_o, in_ready_o, "not idle after last byte")

endmodule

>>> bench/json_string_escaper_tb.sv
module json_string_escaper_tb;

  // Text the block may emit for one transaction (four entries of up to six bytes)
  localparam int unsigned MaxRun      = 24;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 40;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] CtrlTop  = 8'h20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic [7:0] in_byte_i       = 8'h00;
  logic       has_byte_i      = 1'b0;
  logic       end_of_stream_i = 1'b0;
  logic       out_ready_i     = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  bit          idle_en = 1'b1;
  int          err_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;
  int unsigned ready_hold = 0;

  // Decoder state of the predictor
  logic [7:0]  pend_b [3];
  int unsigned pend_n;
  int unsigned seq_len;
  logic [7:0]  run_q [$];
  text_t       text_q [$];

  json_string_escaper u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .has_byte_i      (has_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Escaped-text predictor
  // ---------------------------------------------------------------------------

  function automatic void put_char(logic [7:0] c);
    if (run_q.size() < MaxRun) begin
      run_q.push_back(c);
    end
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    return (v < 4'd10) ? ChZero + 8'(v) : ChLowerA + 8'(v) - 8'd10;
  endfunction

  function automatic void put_hex(logic [7:0] v);
    put_char(ChBslash);
    put_char(ChU);
    put_char(ChZero);
    put_char(ChZero);
    put_char(hex_char(v[7:4]));
    put_char(hex_char(v[3:0]));
  endfunction

  function automatic void put_ascii(logic [7:0] c);
    logic [7:0] letter;
    letter = 8'h00;
    case (c)
      8'h08: letter = 8'h62;  // b
      8'h0C: letter = 8'h66;  // f
      8'h0A: letter = 8'h6E;  // n
      8'h0D: letter = 8'h72;  // r
      8'h09: letter = 8'h74;  // t
      8'h0B: letter = 8'h76;  // v
      8'h22: letter = 8'h22;  // quote
      8'h5C: letter = 8'h5C;  // backslash
      default: ;
    endcase
    if (letter != 8'h00) begin
      put_char(ChBslash);
      put_char(letter);
    end else if (c < CtrlTop) begin
      put_hex(c);
    end else begin
      put_char(c);
    end
  endfunction

  function automatic void clear_pend();
    pend_b  = '{default: 8'h00};
    pend_n  = 0;
    seq_len = 0;
  endfunction

  // Legal continuation range; the second byte is narrowed after some leads
  function automatic void cont_range(input logic [7:0] lead, input bit second,
                                     output logic [7:0] lo, output logic [7:0] hi);
    lo = 8'h80;
    hi = 8'hBF;
    if (second) begin
      case (lead)
        8'hE0: lo = 8'hA0;  // overlong 3-byte
        8'hED: hi = 8'h9F;  // surrogates
        8'hF0: lo = 8'h90;  // overlong 4-byte
        8'hF4: hi = 8'h8F;  // above U+10FFFF
        default: ;
      endcase
    end
  endfunction

  // Byte seen with nothing pending
  function automatic void start_byte(logic [7:0] b);
    if (b < 8'h80) begin
      put_ascii(b);
    end else if (b >= 8'hC2 && b <= 8'hF4) begin
      pend_b[0] = b;
      pend_n    = 1;
      seq_len   = (b < 8'hE0) ? 2 : ((b < 8'hF0) ? 3 : 4);
    end else begin
      put_hex(b);
    end
  endfunction

  function automatic void feed_byte(logic [7:0] b);
    logic [7:0]  held [3];
    int unsigned n;
    logic [7:0]  lo, hi;
    if (pend_n == 0) begin
      start_byte(b);
      return;
    end
    cont_range(pend_b[0], pend_n == 1, lo, hi);
    if (b >= lo && b <= hi) begin
      if (pend_n + 1 >= seq_len) begin
        for (int i = 0; i < pend_n; i++) put_char(pend_b[i]);
        put_char(b);
        clear_pend();
      end else begin
        pend_b[pend_n] = b;
        pend_n++;
      end
    end else begin
      // broken sequence: escape the lead, re-decode the rest
      held = pend_b;
      n    = pend_n;
      clear_pend();
      put_hex(held[0]);
      for (int i = 1; i < n; i++) start_byte(held[i]);
      start_byte(b);
    end
  endfunction

  function automatic void predict_text(logic [7:0] b, logic has, logic eos);
    run_q.delete();
    if (has) begin
      feed_byte(b);
    end
    if (eos) begin
      for (int i = 0; i < pend_n; i++) put_hex(pend_b[i]);
      clear_pend();
    end
    foreach (run_q[i]) begin
      text_q.push_back(text_t'{run_q[i], i == run_q.size() - 1});
    end
  endfunction

  function automatic void check_text(logic [7:0] d, logic l);
    text_t want;
    if (text_q.size() == 0) begin
      $display("%0t: unexpected output byte %02h last %0b", $time, d, l);
      err_cnt++;
    end else begin
      want = text_q.pop_front();
      if (want.data !== d) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.data, d);
        err_cnt++;
      end
      if (want.last !== l) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time, want.last, l);
        err_cnt++;
      end
    end
  endfunction

  // Monitor both channels on the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_text(in_byte_i, has_byte_i, end_of_stream_i);
      end
      if (out_valid_o && out_ready_i) begin
        check_text(out_byte_o, last_of_run_o);
      end
    end
  end

  // Receiver: random stall bursts while idling is on
  always @(posedge clk_i) begin
    if (!idle_en) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      ready_hold  <= $urandom_range(0, 6);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, StallLimit);
      $display("** json_string_escaper: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One input transaction; returns at the edge where it is accepted
  task automatic send_item(input logic [7:0] b, input logic has, input logic eos);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_byte_i       <= b;
    has_byte_i      <= has;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    if (has || eos) begin
      items_sent++;
    end
  endtask

  task automatic test_control_chars();
    logic [7:0] chars [11] = '{8'h00, 8'h1F, 8'h08, 8'h0C, 8'h0A, 8'h0D,
                               8'h09, 8'h0B, 8'h22, 8'h5C, 8'h7F};
    foreach (chars[i]) send_item(chars[i], 1'b1, 1'b0);
  endtask

  task automatic test_lead_bytes();
    // highest code point, then stray continuation and top invalid byte
    send_item(8'hF4, 1'b1, 1'b0);
    send_item(8'h8F, 1'b1, 1'b0);
    send_item(8'hBF, 1'b1, 1'b0);
    send_item(8'hBF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
  endtask

  task automatic test_broken_sequences();
    // overlong second byte after E0
    send_item(8'hE0, 1'b1, 1'b0);
    send_item(8'h9F, 1'b1, 1'b0);
    // truncated sequence flushed by a flush-only transaction
    send_item(8'hE2, 1'b1, 1'b0);
    send_item(8'h82, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    // lead byte and end of stream together
    send_item(8'hF0, 1'b1, 1'b1);
    // flush with nothing pending, then a transaction that does nothing
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
  endtask

  // One random unit: mostly well-formed sequences, some broken ones and noise
  task automatic send_rand_unit();
    int          pick, mode;
    int unsigned len, keep;
    logic [7:0]  seq [4];
    logic [7:0]  lo, hi;
    logic        eos;
    pick = $urandom_range(0, 99);
    eos  = ($urandom_range(0, 9) == 0);
    if (pick < 25) begin
      case ($urandom_range(0, 3))
        0:       seq[0] = 8'($urandom_range(0, 8'h1F));
        1:       seq[0] = $urandom_range(0, 1) ? 8'h22 : 8'h5C;
        default: seq[0] = 8'($urandom_range(0, 8'h7F));
      endcase
      send_item(seq[0], 1'b1, eos);
    end else if (pick < 85) begin
      len = $urandom_range(2, 4);
      case (len)
        2:       seq[0] = 8'($urandom_range(8'hC2, 8'hDF));
        3:       seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
        default: seq[0] = 8'($urandom_range(8'hF0, 8'hF4));
      endcase
      for (int i = 1; i < len; i++) begin
        cont_range(seq[0], i == 1, lo, hi);
        seq[i] = 8'($urandom_range(lo, hi));
      end
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        for (int i = 0; i < len; i++) send_item(seq[i], 1'b1, eos && i == len - 1);
      end else begin
        keep = $urandom_range(1, len - 1);
        for (int i = 0; i < keep; i++) send_item(seq[i], 1'b1, 1'b0);
        if (mode < 9) begin
          send_item(8'($urandom()), 1'b1, $urandom_range(0, 1) == 0);
        end else begin
          send_item(8'($urandom()), 1'b0, 1'b1);
        end
      end
    end else if (pick < 97) begin
      send_item(8'($urandom()), 1'b1, $urandom_range(0, 7) == 0);
    end else begin
      send_item(8'($urandom()), 1'b0, 1'b0);
    end
  endtask

  task automatic test_random_traffic(input int unsigned n);
    int unsigned first;
    first = items_sent;
    while (items_sent - first < n) send_rand_unit();
  endtask

  // Sender holds off until all expected text is out
  task automatic test_drain_pause();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (text_q.size() != 0);
  endtask

  initial begin
    clear_pend();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_control_chars();
    test_lead_bytes();
    test_broken_sequences();
    test_random_traffic(150);
    test_drain_pause();
    test_random_traffic(80);
    idle_en = 1'b0;
    test_random_traffic(80);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (text_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && text_q.size() == 0) begin
      $display("** json_string_escaper: PASSED **");
    end else begin
      $display("** json_string_escaper: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/jse_pkg.sv
rtl/json_string_escaper.sv
bench/json_string_escaper_tb.sv
